FILE: hdl/object_list_tile_emitter_defines.svh
// assertion macros shared by the checker
`ifndef OBJECT_LIST_TILE_EMITTER_DEFINES_SVH
`define OBJECT_LIST_TILE_EMITTER_DEFINES_SVH

// payload of a stalled beat holds
`define OLTE_ASSERT_HOLD(lbl, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
		else $error("stalled beat changed or dropped");

// plain implication check
`define OLTE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) \
		else $error("implication check failed");

`endif

FILE: hdl/olte_pkg.sv
`default_nettype none
package olte_pkg;

	localparam logic [7:0]  SpriteYTop     = 8'd240;
	localparam logic [12:0] ColumnWordBase = 13'h200;
	localparam logic [5:0]  SpriteLastIdx  = 6'd3;
	localparam logic [5:0]  ColumnLastIdx  = 6'd63;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'b01,
		CMD_ENTRY = 2'b10
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [13:0] addr;
		logic [7:0]  data;
		logic        column;
		logic [12:0] base;
		logic [7:0]  sy;
		logic [7:0]  cx;
		logic [3:0]  color;
	} cmd_t;

	typedef struct packed {
		logic [3:0] color;
		logic [7:0] x;
		logic [7:0] y;
		logic       last;
	} tile_meta_t;

	typedef struct packed {
		logic [13:0] code;
		logic [3:0]  color;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        last;
	} tile_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

FILE: hdl/olte_if.sv
`default_nettype none
interface olte_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [13:0] vram_addr;
	logic [7:0]  vram_data;
	logic        first_entry;
	logic [7:0]  obj_y;
	logic [7:0]  obj_num;
	logic [7:0]  obj_x;
	logic [7:0]  obj_attr;

	modport source (output valid, func, vram_addr, vram_data, first_entry, obj_y, obj_num,
		obj_x, obj_attr, input ready);
	modport sink (input valid, func, vram_addr, vram_data, first_entry, obj_y, obj_num,
		obj_x, obj_attr, output ready);
endinterface

interface olte_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] tile_code;
	logic [3:0]  tile_color;
	logic [7:0]  tile_x;
	logic [7:0]  tile_y;
	logic        last;

	modport source (output valid, tile_code, tile_color, tile_x, tile_y, last, input ready);
	modport sink (input valid, tile_code, tile_color, tile_x, tile_y, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/olte_ram.sv
`default_nettype none
module olte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/olte_front.sv
`default_nettype none
module olte_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	olte_in_if.sink      item,
	input  wire olte_pkg::q_stat_t stat,
	output logic         push,
	output olte_pkg::cmd_t cmd
);
	import olte_pkg::*;

	logic       accept;
	logic       blank;
	logic [7:0] cx_base;
	logic [7:0] cx_new;
	logic [7:0] column_x_q;

	assign item.ready = !stat.full;
	assign accept     = item.valid && item.ready;

	always_comb begin
		blank   = (item.obj_y == 8'd0) && (item.obj_num == 8'd0) &&
			(item.obj_x == 8'd0) && (item.obj_attr == 8'd0);
		cx_base = item.first_entry ? 8'd0 : column_x_q;
		if (item.obj_num[7] && item.obj_num[6]) begin
			cx_new = cx_base + 8'd16;
		end else begin
			cx_new = item.obj_x;
		end

		cmd.kind   = item.func ? CMD_ENTRY : CMD_WRITE;
		cmd.addr   = item.vram_addr;
		cmd.data   = item.vram_data;
		cmd.column = item.obj_num[7];
		if (item.obj_num[7]) begin
			cmd.base = {1'b0, item.obj_num[5:0], 6'b0} + ColumnWordBase;
			cmd.sy   = 8'd0 - item.obj_y;
		end else begin
			cmd.base = {4'b0, item.obj_num[6:0], 2'b0};
			cmd.sy   = SpriteYTop - item.obj_y;
		end
		cmd.cx    = cx_new;
		cmd.color = item.obj_attr[3:0];

		push = accept && (!item.func || !blank);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_x_q <= 8'd0;
		end else if (accept && item.func) begin
			column_x_q <= blank ? cx_base : cx_new;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/olte_cmd_queue.sv
`default_nettype none
module olte_cmd_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire olte_pkg::cmd_t push_cmd,
	input  wire logic     pop,
	output olte_pkg::cmd_t head,
	output olte_pkg::q_stat_t stat
);
	import olte_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head       = ent_q[rd_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/olte_back.sv
`default_nettype none
module olte_back #(
	parameter int VRAM_BYTES = 16384
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire olte_pkg::cmd_t head,
	input  wire olte_pkg::q_stat_t stat,
	output logic          pop,
	olte_out_if.source    tile
);
	import olte_pkg::*;

	localparam int Words = VRAM_BYTES / 2;
	localparam int WAW   = $clog2(Words);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t     state_q;
	cmd_t       cur_q;
	logic [5:0] n_q;
	logic       v_s1;
	tile_meta_t meta_s1;
	tile_t      fifo_q [2];
	logic       fwr_q;
	logic       frd_q;
	logic [1:0] cnt_q;

	logic        take;
	logic [1:0]  occ;
	logic        room;
	logic        issue;
	logic        last_n;
	logic        half;
	logic [4:0]  row;
	logic [12:0] rd_word;
	tile_meta_t  meta;
	logic        we;
	logic [7:0]  lo;
	logic [7:0]  hi;
	tile_t       beat;

	always_comb begin
		take   = tile.valid && tile.ready;
		occ    = cnt_q + {1'b0, v_s1};
		room   = (occ < 2'd2) || ((occ == 2'd2) && take);
		issue  = (state_q == ST_BUSY) && room;
		last_n = cur_q.column ? (n_q == ColumnLastIdx) : (n_q == SpriteLastIdx);
		half   = cur_q.column ? n_q[5] : n_q[1];
		row    = cur_q.column ? n_q[4:0] : {4'b0, n_q[0]};
		rd_word = cur_q.base + {7'b0, n_q};
		meta.color = cur_q.color;
		meta.x     = cur_q.cx + {4'b0, half, 3'b0};
		meta.y     = cur_q.sy + {row, 3'b0};
		meta.last  = last_n;
		pop = (state_q == ST_IDLE) && !stat.empty;
		we  = pop && (head.kind == CMD_WRITE);
		beat.code  = {hi[5:0], lo};
		beat.color = meta_s1.color | {2'b0, hi[7:6]};
		beat.x     = meta_s1.x;
		beat.y     = meta_s1.y;
		beat.last  = meta_s1.last;
	end

	olte_ram #(.WIDTH(8), .DEPTH(Words)) u_ram_lo (
		.clk   (clk),
		.we    (we && !head.addr[0]),
		.waddr (WAW'(head.addr[13:1])),
		.wdata (head.data),
		.raddr (WAW'(rd_word)),
		.rdata (lo)
	);

	olte_ram #(.WIDTH(8), .DEPTH(Words)) u_ram_hi (
		.clk   (clk),
		.we    (we && head.addr[0]),
		.waddr (WAW'(head.addr[13:1])),
		.wdata (head.data),
		.raddr (WAW'(rd_word)),
		.rdata (hi)
	);

	assign tile.valid      = (cnt_q != 2'd0);
	assign tile.tile_code  = fifo_q[frd_q].code;
	assign tile.tile_color = fifo_q[frd_q].color;
	assign tile.tile_x     = fifo_q[frd_q].x;
	assign tile.tile_y     = fifo_q[frd_q].y;
	assign tile.last       = fifo_q[frd_q].last;

	always_ff @(posedge clk) begin
		if (pop && (head.kind == CMD_ENTRY)) begin
			cur_q <= head;
		end
		if (issue) begin
			meta_s1 <= meta;
		end
		if (v_s1) begin
			fifo_q[fwr_q] <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= 6'd0;
			v_s1    <= 1'b0;
			fwr_q   <= 1'b0;
			frd_q   <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			v_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (pop && (head.kind == CMD_ENTRY)) begin
						n_q     <= 6'd0;
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (issue) begin
						n_q <= n_q + 6'd1;
						if (last_n) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_s1) begin
				fwr_q <= !fwr_q;
			end
			if (take) begin
				frd_q <= !frd_q;
			end
			if (v_s1 && !take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (take && !v_s1) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/object_list_tile_emitter.sv
// Object-list tile emitter. Each beat on item either writes one video RAM byte
// (func 0) or expands one four-byte object entry (func 1) into 8x8 tile draw
// beats on tile: 4 for a sprite, 64 for a column, none for an all-zero entry,
// with last set on the final tile of an entry. A front stage classifies beats,
// tracks the running column x and feeds a two-entry command queue; the back
// sequencer executes commands in order against two byte-wide RAM banks (even
// and odd bytes) read as one 16-bit word per cycle. A write is taken in the idle
// state; an entry is loaded in the idle state and then issues one tile per cycle
// while the output queue has room, bounded by the single read port of the
// banks, with a two-deep output queue so tile stalls do not stop item intake
// until the command queue fills. Video RAM contents are undefined until
// written and there is no clearing pass after reset.
`default_nettype none
module object_list_tile_emitter #(
	parameter int VRAM_BYTES = 16384
) (
	input  wire logic clk,
	input  wire logic arst_n,
	olte_in_if.sink    item,
	olte_out_if.source tile
);
	import olte_pkg::*;

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t stat;

	olte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.stat   (stat),
		.push   (push),
		.cmd    (push_cmd)
	);

	olte_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	olte_back #(.VRAM_BYTES(VRAM_BYTES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.tile   (tile)
	);
endmodule
`default_nettype wire

FILE: hdl/olte_checker.sv
`default_nettype none
`include "object_list_tile_emitter_defines.svh"
module olte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_ready,
	input wire logic        tile_valid,
	input wire logic        tile_ready,
	input wire logic [34:0] tile_beat
);
	`OLTE_ASSERT_HOLD(a_tile_hold, tile_valid, tile_ready, tile_beat)
	`OLTE_ASSERT_IMPL(a_no_tile_after_reset, !$past(arst_n), !tile_valid)
	`OLTE_ASSERT_IMPL(a_ready_after_reset, !$past(arst_n), item_ready)
	`OLTE_ASSERT_IMPL(a_no_tile_idle, !$past(tile_valid) && !$past(tile_valid, 2) && !$past(arst_n, 2), !tile_valid)
endmodule

bind object_list_tile_emitter olte_checker u_olte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.tile_valid (tile.valid),
	.tile_ready (tile.ready),
	.tile_beat  ({tile.tile_code, tile.tile_color, tile.tile_x, tile.tile_y, tile.last})
);
`default_nettype wire

FILE: sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olte_pkg::*;

	localparam int          VRAM_BYTES   = 16384;
	localparam logic        FUNC_WRITE   = 1'b0;
	localparam logic        FUNC_ENTRY   = 1'b1;
	localparam logic [13:0] COLUMN_BASE  = 14'h0400;
	localparam int          RANDOM_BEATS = 50;
	localparam int          CALM_AFTER   = 40;
	localparam int          HOLD_AFTER   = 10;
	localparam int          SEG_BEATS    = 10;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          CYCLE_LIMIT  = 3000000;

	typedef struct packed {
		logic        func;
		logic [13:0] addr;
		logic [7:0]  data;
		logic        frame_start;
		logic [7:0]  obj_y;
		logic [7:0]  obj_num;
		logic [7:0]  obj_x;
		logic [7:0]  obj_attr;
	} item_beat_t;

	class tile_scoreboard;
		logic [7:0] vram [VRAM_BYTES];
		logic [7:0] column_x;
		tile_t      pending[$];
		int         mismatches;
		int         tiles_checked;
		int         writes_seen;
		int         entries_seen;
		int         columns_seen;

		function new();
			column_x      = 8'd0;
			mismatches    = 0;
			tiles_checked = 0;
			writes_seen   = 0;
			entries_seen  = 0;
			columns_seen  = 0;
		endfunction

		// expand one accepted beat into the tiles it should produce
		function void note_item(item_beat_t b);
			logic [13:0] base;
			logic [13:0] addr;
			logic [7:0]  sy;
			logic [7:0]  lo;
			logic [7:0]  hi;
			tile_t       t;
			int          height;
			int          half;
			int          row;
			if (b.func == FUNC_WRITE) begin
				vram[b.addr] = b.data;
				writes_seen++;
				return;
			end
			entries_seen++;
			if (b.frame_start)
				column_x = 8'd0;
			if ({b.obj_y, b.obj_num, b.obj_x, b.obj_attr} == 32'd0)
				return;
			if (!b.obj_num[7]) begin
				base     = {4'd0, b.obj_num[6:0], 3'd0};
				height   = 2;
				column_x = b.obj_x;
			end else begin
				base     = {1'b0, b.obj_num[5:0], 7'd0} + COLUMN_BASE;
				height   = 32;
				column_x = b.obj_num[6] ? column_x + 8'd16 : b.obj_x;
				columns_seen++;
			end
			sy = 8'(256 - height * 8 - int'(b.obj_y));
			for (half = 0; half < 2; half++) begin
				addr = base + 14'(half * height * 2);
				for (row = 0; row < height; row++) begin
					lo      = vram[addr];
					hi      = vram[addr + 14'd1];
					t.code  = {hi[5:0], lo};
					t.color = {2'b00, hi[7:6]} | b.obj_attr[3:0];
					t.x     = column_x + 8'(half * 8);
					t.y     = sy + 8'(row * 8);
					t.last  = (half == 1) && (row == height - 1);
					pending.push_back(t);
					addr += 14'd2;
				end
			end
		endfunction

		function void check_tile(tile_t got);
			tile_t want;
			tiles_checked++;
			if (pending.size() == 0) begin
				if (mismatches < 10)
					$display("tile beat %0d unexpected: code %h color %h x %h y %h last %b",
						tiles_checked, got.code, got.color, got.x, got.y, got.last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.code !== want.code || got.color !== want.color || got.x !== want.x ||
					got.y !== want.y || got.last !== want.last) begin
				if (mismatches < 10) begin
					$display("tile beat %0d expected: code %h color %h x %h y %h last %b",
						tiles_checked, want.code, want.color, want.x, want.y, want.last);
					$display("tile beat %0d actual:   code %h color %h x %h y %h last %b",
						tiles_checked, got.code, got.color, got.x, got.y, got.last);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	olte_in_if  item_bus();
	olte_out_if tile_bus();

	object_list_tile_emitter #(.VRAM_BYTES(VRAM_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.tile(tile_bus)
	);

	tile_scoreboard sb = new();

	bit vram_written [VRAM_BYTES];
	int beats_sent  = 0;
	int gap_pct     = 0;
	int stall_pct   = 0;
	bit calm        = 1'b0;
	bit hold_req    = 1'b0;
	int cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("object_list_tile_emitter: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready)
				sb.note_item(item_beat_t'({item_bus.func, item_bus.vram_addr, item_bus.vram_data,
					item_bus.first_entry, item_bus.obj_y, item_bus.obj_num, item_bus.obj_x,
					item_bus.obj_attr}));
			if (tile_bus.valid && tile_bus.ready)
				sb.check_tile(tile_t'({tile_bus.tile_code, tile_bus.tile_color, tile_bus.tile_x,
					tile_bus.tile_y, tile_bus.last}));
		end
	end

	// tile receiver: random stall bursts plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		tile_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				tile_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && stall > 0) begin
				tile_bus.ready <= 1'b0;
				stall--;
			end else begin
				tile_bus.ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < stall_pct)
					stall = $urandom_range(1, 17);
			end
		end
	end

	task automatic send_beat(item_beat_t b);
		int gap;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 17);
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.func        <= b.func;
		item_bus.vram_addr   <= b.addr;
		item_bus.vram_data   <= b.data;
		item_bus.first_entry <= b.frame_start;
		item_bus.obj_y       <= b.obj_y;
		item_bus.obj_num     <= b.obj_num;
		item_bus.obj_x       <= b.obj_x;
		item_bus.obj_attr    <= b.obj_attr;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		beats_sent++;
		if (b.func == FUNC_WRITE)
			vram_written[b.addr] = 1'b1;
	endtask

	task automatic send_write(logic [13:0] addr, logic [7:0] data);
		item_beat_t b;
		b = '{func: FUNC_WRITE, addr: addr, data: data, frame_start: 1'($urandom),
			obj_y: 8'($urandom), obj_num: 8'($urandom), obj_x: 8'($urandom),
			obj_attr: 8'($urandom)};
		send_beat(b);
	endtask

	// any ram byte the entry will read gets written first
	task automatic send_entry(logic frame_start, logic [7:0] y, logic [7:0] num,
			logic [7:0] x, logic [7:0] attr);
		item_beat_t  b;
		logic [13:0] base;
		int          len;
		int          i;
		base = 14'd0;
		len  = 0;
		if ({y, num, x, attr} != 32'd0) begin
			if (!num[7]) begin
				base = {4'd0, num[6:0], 3'd0};
				len  = 8;
			end else begin
				base = {1'b0, num[5:0], 7'd0} + COLUMN_BASE;
				len  = 128;
			end
		end
		for (i = 0; i < len; i++)
			if (!vram_written[base + 14'(i)])
				send_write(base + 14'(i), 8'($urandom));
		b = '{func: FUNC_ENTRY, addr: 14'($urandom), data: 8'($urandom),
			frame_start: frame_start, obj_y: y, obj_num: num, obj_x: x, obj_attr: attr};
		send_beat(b);
	endtask

	initial begin
		int         i;
		int         done;
		int         next_seg;
		int         rand_start;
		int         pick;
		bit         hold_done;
		logic [7:0] sprite_pool [8];

		arst_n               <= 1'b0;
		item_bus.valid       <= 1'b0;
		item_bus.func        <= FUNC_WRITE;
		item_bus.vram_addr   <= 14'd0;
		item_bus.vram_data   <= 8'd0;
		item_bus.first_entry <= 1'b0;
		item_bus.obj_y       <= 8'd0;
		item_bus.obj_num     <= 8'd0;
		item_bus.obj_x       <= 8'd0;
		item_bus.obj_attr    <= 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (i = 0; i < 8; i++)
			send_write(14'(i), (i[0] ^ i[1]) ? 8'hff : 8'h00);
		send_write(14'h3fff, 8'hff);
		send_entry(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_entry(1'b0, 8'h01, 8'h00, 8'h00, 8'h00);
		send_entry(1'b0, 8'hff, 8'h7f, 8'hff, 8'hff);
		send_entry(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_entry(1'b0, 8'h00, 8'hc0, 8'h00, 8'h00);
		send_entry(1'b0, 8'h10, 8'h80, 8'hf8, 8'h0f);
		send_entry(1'b0, 8'h20, 8'hc0, 8'h00, 8'h40);
		send_entry(1'b0, 8'hff, 8'hbf, 8'h10, 8'h05);
		send_entry(1'b0, 8'h00, 8'hff, 8'h33, 8'h0a);
		send_entry(1'b1, 8'h00, 8'hff, 8'h77, 8'h00);
		send_entry(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_entry(1'b0, 8'h00, 8'hff, 8'h00, 8'hf0);
		send_entry(1'b1, 8'h08, 8'h00, 8'h80, 8'h00);
		send_entry(1'b0, 8'h00, 8'h00, 8'h00, 8'h01);
		send_entry(1'b0, 8'h00, 8'h00, 8'h01, 8'h00);
		send_entry(1'b0, 8'h00, 8'h40, 8'h20, 8'h80);

		// random part: frames of sprites and columns from small pools, plus ram writes
		sprite_pool[0] = 8'h00;
		sprite_pool[1] = 8'h7f;
		for (i = 2; i < 8; i++)
			sprite_pool[i] = 8'($urandom_range(0, 127));
		hold_done  = 1'b0;
		next_seg   = 0;
		rand_start = beats_sent;
		while (beats_sent - rand_start < RANDOM_BEATS) begin
			done = beats_sent - rand_start;
			if (done >= CALM_AFTER)
				calm = 1'b1;
			if (done >= next_seg) begin
				gap_pct   = 20 * $urandom_range(0, 2);
				stall_pct = 20 * $urandom_range(0, 2);
				next_seg += SEG_BEATS;
			end
			if (!hold_done && done >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_req  = 1'b1;
				repeat (4)
					send_entry(1'b0, 8'($urandom), {2'b11, 6'h3f}, 8'($urandom), 8'($urandom));
			end
			pick = $urandom_range(0, 99);
			if (pick < 25)
				send_write(14'($urandom), 8'($urandom));
			else if (pick < 30)
				send_entry(1'($urandom), 8'h00, 8'h00, 8'h00, 8'h00);
			else if (pick < 70)
				send_entry($urandom_range(0, 7) == 0, 8'($urandom),
					sprite_pool[$urandom_range(0, 7)], 8'($urandom), 8'($urandom));
			else
				send_entry($urandom_range(0, 7) == 0, 8'($urandom),
					{1'b1, 1'($urandom), $urandom_range(0, 1) ? 6'h3f : 6'h00},
					8'($urandom), 8'($urandom));
		end
		item_bus.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d ram writes and %0d object entries (%0d columns)",
			sb.writes_seen, sb.entries_seen, sb.columns_seen);
		$display("%0d tile beats compared, including a long output hold-off with input backpressure",
			sb.tiles_checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("object_list_tile_emitter: match");
		else
			$display("object_list_tile_emitter: mismatch");
		$finish;
	end
endmodule
